### design/merge_sort_engine_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the merge sort engine
// Short forms for clocked concurrent assertions with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_CORE_ASSERT_SVH
`define MERGE_SORT_ENGINE_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define MSE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The antecedent implies the consequent in the next cycle.
`define MSE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### design/mse_pkg.sv
// ---------------------------------------------------------------------------
// Merge sort engine package
// The value width and the control bundle shared by the core and its sorting cells.
// ---------------------------------------------------------------------------
package mse_pkg;

  localparam int unsigned ValueW = 32;

  // Control broadcast from the core to every cell of the row.
  typedef struct packed {
    logic              insert;
    logic              drain;
    logic [ValueW-1:0] sample;
  } mse_ctrl_t;

endpackage

### design/mse_cell.sv
// ---------------------------------------------------------------------------
// Merge sort engine cell
// One slot of the sorted row: compares the broadcast sample with its value,
// takes the sample or its left neighbor on insert, its right neighbor on drain.
// ---------------------------------------------------------------------------
module mse_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mse_pkg::mse_ctrl_t        ctrl_i,
  input  logic                      prev_take_i,
  input  logic [mse_pkg::ValueW-1:0] prev_value_i,
  input  logic                      prev_valid_i,
  input  logic [mse_pkg::ValueW-1:0] next_value_i,
  input  logic                      next_valid_i,
  output logic                      take_o,
  output logic [mse_pkg::ValueW-1:0] value_o,
  output logic                      valid_o
);

  logic [mse_pkg::ValueW-1:0] value_q, value_d;
  logic                      valid_q, valid_d;

  // An empty slot counts as larger than any value. Strict compare keeps
  // equal values in load order.
  assign take_o = !valid_q || ($signed(ctrl_i.sample) < $signed(value_q));

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert) begin
      if (prev_take_i) begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else if (take_o) begin
        value_d = ctrl_i.sample;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.drain) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

### design/merge_sort_engine_core.sv
// ---------------------------------------------------------------------------
// Merge sort engine core
// Stable ascending sort of signed 32-bit values in a row of insertion cells.
// ---------------------------------------------------------------------------
// A value is taken whenever start is high and busy is low, one per cycle,
// and is placed into its sorted position in the cell row at once. Equal values
// keep their load order. Up to DEPTH values are kept; further values of the set
// are dropped and every result of that set shows overflowed_o. After the value
// marked end_of_set_i is taken, busy rises and the set leaves in ascending
// order, one value per cycle on result_strobe_o, the last marked end_of_run_o.
// The drain is a shift of the cell row toward its head. The receiver cannot
// stall the drain, so results must be taken on the cycle they are shown.
// ---------------------------------------------------------------------------
module merge_sort_engine_core #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [mse_pkg::ValueW-1:0] sample_value_i,
  input  logic                      end_of_set_i,
  output logic                      result_strobe_o,
  output logic [mse_pkg::ValueW-1:0] sorted_value_o,
  output logic                      end_of_run_o,
  output logic                      overflowed_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              drop_q, drop_d;
  logic              accept;
  logic              full;
  logic              last_out;
  mse_pkg::mse_ctrl_t ctrl;

  logic                      take_w  [DEPTH];
  logic [mse_pkg::ValueW-1:0] value_w [DEPTH];
  logic                      valid_w [DEPTH];

  assign accept   = start && !busy;
  assign full     = (fill_q == CntW'(DEPTH));
  assign last_out = !valid_w[1];

  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = (state_q == ST_DRAIN);
  assign ctrl.sample = sample_value_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      prev_take;
    logic [mse_pkg::ValueW-1:0] prev_value;
    logic                      prev_valid;
    logic [mse_pkg::ValueW-1:0] next_value;
    logic                      next_valid;

    if (i == 0) begin : g_head
      assign prev_take  = 1'b0;
      assign prev_value = '0;
      assign prev_valid = 1'b0;
    end else begin : g_body
      assign prev_take  = take_w[i-1];
      assign prev_value = value_w[i-1];
      assign prev_valid = valid_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_value = value_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    mse_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_take_i (prev_take),
      .prev_value_i(prev_value),
      .prev_valid_i(prev_valid),
      .next_value_i(next_value),
      .next_valid_i(next_valid),
      .take_o      (take_w[i]),
      .value_o     (value_w[i]),
      .valid_o     (valid_w[i])
    );
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    drop_d  = drop_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            fill_d = fill_q + 1'b1;
          end
          if (end_of_set_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (last_out) begin
          state_d = ST_LOAD;
          fill_d  = '0;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
    end
  end

  assign busy            = (state_q == ST_DRAIN);
  assign result_strobe_o = (state_q == ST_DRAIN);
  assign sorted_value_o  = value_w[0];
  assign end_of_run_o    = (state_q == ST_DRAIN) && last_out;
  assign overflowed_o    = drop_q;

endmodule

### design/mse_checker.sv
// ---------------------------------------------------------------------------
// Merge sort engine port checker
// Watches the core's ports for a well-formed, ordered result stream.
// ---------------------------------------------------------------------------
`include "merge_sort_engine_core_assert.svh"

module mse_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      end_of_set_i,
  input logic                      result_strobe_o,
  input logic [mse_pkg::ValueW-1:0] sorted_value_o,
  input logic                      end_of_run_o,
  input logic                      overflowed_o
);

  logic                             marked_accept;
  logic                             more_results;
  logic                             final_result;
  logic signed [mse_pkg::ValueW-1:0] sorted_s;

  assign marked_accept = start && !busy && end_of_set_i;
  assign more_results  = result_strobe_o && !end_of_run_o;
  assign final_result  = result_strobe_o && end_of_run_o;
  assign sorted_s      = sorted_value_o;

  // A marked transaction starts the result stream on the next cycle.
  `MSE_ASSERT_NEXT(a_run_starts, clk_i, rst_ni, marked_accept, result_strobe_o)

  // Results come without gaps until the final one.
  `MSE_ASSERT_NEXT(a_run_contiguous, clk_i, rst_ni, more_results, result_strobe_o)

  // The engine frees itself right after the final result.
  `MSE_ASSERT_NEXT(a_run_ends, clk_i, rst_ni, final_result, !busy)

  // Values of one run never decrease.
  `MSE_ASSERT_NEXT(a_run_ordered, clk_i, rst_ni, more_results, sorted_s >= $past(sorted_s))

  // The overflow flag is the same on every result of a run.
  `MSE_ASSERT_NEXT(a_ovf_stable, clk_i, rst_ni, more_results, $stable(overflowed_o))

endmodule

bind merge_sort_engine_core mse_checker u_mse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .end_of_set_i   (end_of_set_i),
  .result_strobe_o(result_strobe_o),
  .sorted_value_o (sorted_value_o),
  .end_of_run_o   (end_of_run_o),
  .overflowed_o   (overflowed_o)
);

### tb/merge_sort_engine_core_test.sv
// ---------------------------------------------------------------------------
// Merge sort engine core testbench
// Sends sets of signed samples through the start/busy command port. A
// stable insertion sort in the bench builds the expected sorted sequence for
// each set. Every strobed result is checked against that sequence: its
// value, its end-of-run mark and its overflow flag.
// ---------------------------------------------------------------------------
module merge_sort_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ValueW     = mse_pkg::ValueW;
  localparam int unsigned DEPTH      = 32;
  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned DrainWait  = 2 * DEPTH + 8;
  localparam int unsigned CycleLimit = 400000;

  localparam logic [ValueW-1:0] MinValue = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic [ValueW-1:0] MaxValue = ~MinValue;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              end_of_run;
    logic              overflowed;
  } sorted_result_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic [ValueW-1:0] sample_value_i = '0;
  logic              end_of_set_i   = 1'b0;
  logic              result_strobe_o;
  logic [ValueW-1:0] sorted_value_o;
  logic              end_of_run_o;
  logic              overflowed_o;

  // Bench copy of the engine state: the values of the open set and its drop flag.
  logic [ValueW-1:0] set_values[$];
  logic              set_dropped = 1'b0;
  sorted_result_t    expected_sorted[$];
  sorted_result_t    next_expected;

  int unsigned sender_idle_pct = 0;
  int unsigned items_sent      = 0;
  int unsigned sets_sorted     = 0;
  int unsigned overflow_sets   = 0;
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  merge_sort_engine_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_value_i (sample_value_i),
    .end_of_set_i   (end_of_set_i),
    .result_strobe_o(result_strobe_o),
    .sorted_value_o (sorted_value_o),
    .end_of_run_o   (end_of_run_o),
    .overflowed_o   (overflowed_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_sorted.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Updates the bench state for one accepted sample and, at the end of a set,
  // queues the set in stable ascending order.
  task automatic load_sample(input logic [ValueW-1:0] value, input logic last);
    logic [ValueW-1:0] ordered[$];
    sorted_result_t    res;
    int unsigned       pos;
    if (set_values.size() < DEPTH) begin
      set_values.push_back(value);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      // Equal values stay behind the ones loaded earlier.
      foreach (set_values[i]) begin
        pos = ordered.size();
        while (pos > 0 && $signed(ordered[pos-1]) > $signed(set_values[i])) pos--;
        ordered.insert(pos, set_values[i]);
      end
      foreach (ordered[k]) begin
        res.value      = ordered[k];
        res.end_of_run = (k == ordered.size() - 1);
        res.overflowed = set_dropped;
        expected_sorted.push_back(res);
      end
      sets_sorted++;
      if (set_dropped) overflow_sets++;
      set_values.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Presents one sample and returns at the edge where the engine takes it.
  task automatic send_sample(input logic [ValueW-1:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    sample_value_i <= value;
    end_of_set_i   <= last;
    do @(posedge clk_i); while (busy);
    load_sample(value, last);
    items_sent++;
  endtask

  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(4))
      0: return $urandom;
      1: return ValueW'(int'($urandom_range(16)) - 8);
      2: begin
        case ($urandom_range(5))
          0: return MinValue;
          1: return MaxValue;
          2: return MinValue + 1;
          3: return MaxValue - 1;
          4: return '0;
          default: return '1;
        endcase
      end
      // A coarse pool so that sets often hold equal values of both signs.
      3: return ValueW'($urandom_range(3)) << (ValueW - 2);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_set_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(DEPTH, 9);
    return $urandom_range(DEPTH + 4, DEPTH + 1);
  endfunction

  task automatic send_set(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(random_value(), i == len - 1);
    end
  endtask

  task automatic test_directed_extremes();
    sender_idle_pct = 0;
    // Mixed extremes with repeats and both alternating bit patterns.
    send_sample(MaxValue, 1'b0);
    send_sample(MinValue, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(MaxValue, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(MinValue, 1'b1);
    // A set of one value: its only result carries the end-of-run mark.
    send_sample(MinValue, 1'b1);
    send_sample(MaxValue, 1'b1);
    // Descending pair, then a run of equal values.
    send_sample(32'd5, 1'b0);
    send_sample(-32'sd5, 1'b1);
    send_sample(32'd7, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(32'd7, 1'b1);
  endtask

  task automatic test_store_overflow();
    sender_idle_pct = 24;
    send_set(DEPTH);
    send_set(DEPTH + 1);  // the marked sample itself is dropped
    send_set(DEPTH + 3);
    send_set(1);          // drop flag must be clear again
  endtask

  task automatic test_random_sets(input int unsigned idle_pct, input int unsigned item_goal);
    int unsigned first_item;
    sender_idle_pct = idle_pct;
    first_item = items_sent;
    while (items_sent - first_item < item_goal) send_set(pick_set_len());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (expected_sorted.size() == 0) begin
        $display("%0t: result with nothing expected: value %0d end_of_run %b overflowed %b",
                 $time, $signed(sorted_value_o), end_of_run_o, overflowed_o);
        error_count++;
      end else begin
        next_expected = expected_sorted.pop_front();
        results_checked++;
        if (sorted_value_o !== next_expected.value) begin
          $display("%0t: sorted_value expected %0d actual %0d", $time,
                   $signed(next_expected.value), $signed(sorted_value_o));
          error_count++;
        end
        if (end_of_run_o !== next_expected.end_of_run) begin
          $display("%0t: end_of_run expected %b actual %b", $time,
                   next_expected.end_of_run, end_of_run_o);
          error_count++;
        end
        if (overflowed_o !== next_expected.overflowed) begin
          $display("%0t: overflowed expected %b actual %b", $time,
                   next_expected.overflowed, overflowed_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_store_overflow();
    test_random_sets(24, 100);
    test_random_sets(85, 100);
    test_random_sets(0, 100);
    start <= 1'b0;

    while (expected_sorted.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sorted %0d sets from %0d samples, %0d of them past the store depth.",
             sets_sorted, items_sent, overflow_sets);
    $display("Checked %0d results, with sender gaps at 24, 85 and 0 percent.",
             results_checked);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
